// ===== rtl/ihq_pkg.sv =====
`timescale 1ns / 1ps

package ihq_pkg;

	localparam int CAPACITY  = 1024;
	localparam int KEY_COUNT = 1024;
	localparam int KEY_W     = 10;
	localparam int PRIO_W    = 32;
	localparam int SLOT_W    = 10;
	localparam int FILL_W    = 11;

	localparam logic [FILL_W-1:0] NO_SLOT   = '1;
	localparam logic [PRIO_W-1:0] SIGN_FLIP = 32'h8000_0000;
	localparam logic [PRIO_W-1:0] ONE_UNIT  = 32'h0001_0000;

	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_REMOVE = 3'd1;
	localparam logic [2:0] OP_POP    = 3'd2;
	localparam logic [2:0] OP_SET    = 3'd3;
	localparam logic [2:0] OP_DEC    = 3'd4;
	localparam logic [2:0] OP_QUERY  = 3'd5;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DISP,
		S_POP_RD,
		S_LOAD_LAST,
		S_DEC_RD,
		S_UP_RD,
		S_UP_CMP,
		S_DN_RDL,
		S_DN_RDR,
		S_DN_CMP,
		S_WR_FIN,
		S_FIN_RD,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [2:0]        opcode;
		logic [KEY_W-1:0]  key;
		logic [PRIO_W-1:0] priority_req;
	} in_item_t;

	typedef struct packed {
		logic [KEY_W-1:0]  best_key;
		logic              is_member;
		logic [FILL_W-1:0] slot_of_key;
		logic [FILL_W-1:0] entry_count;
		logic [1:0]        status;
	} out_item_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [PRIO_W-1:0] prio;
	} slot_ent_t;

endpackage

// ===== rtl/indexed_binary_heap_queue_unit.sv =====
`timescale 1ns / 1ps

// indexed binary heap priority queue: keys with signed q16.16 priorities sit in
// a heap of up to 1024 slots, and a key-to-slot map gives each key's slot. one
// request is one operation (insert, remove, pop best, set, decrement, query)
// and yields one result. a request that moves nothing (query, refused insert,
// pop from an empty heap) goes from dispatch straight to the result states; an
// insert, set, remove, pop or decrement also loads and settles the moving entry,
// if there is one, with a parent read and a compare for each level it climbs and
// a left read, a right read and a compare for each level it sinks. these steps
// are paced by the single read port of the slot memory: one read per level
// climbed, two (both children) per level sunk. after reset the key map is swept
// to absent, and no request is taken during the sweep; min_mode writes take
// effect at once and belong between requests, with nothing in flight. a finished result
// is held in an output register, so the next request may be taken while it
// waits.

module indexed_binary_heap_queue_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ihq_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output ihq_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic               cfg_wdata
);

	ihq_pkg::state_t state_q, state_d;

	logic                          min_mode_q;
	logic [ihq_pkg::SLOT_W-1:0]    clr_q;
	logic [2:0]                    op_q;
	logic [ihq_pkg::KEY_W-1:0]     key_q;
	logic [ihq_pkg::PRIO_W-1:0]    prio_q;
	logic [ihq_pkg::FILL_W-1:0]    fill_q;
	logic [ihq_pkg::SLOT_W-1:0]    hole_q;
	logic                          up_q;
	logic                          more_q;
	logic                          has_r_q;
	ihq_pkg::slot_ent_t            mov_q;
	ihq_pkg::slot_ent_t            lft_q;
	logic [ihq_pkg::KEY_W-1:0]     best_q;
	logic [1:0]                    stat_q;
	logic                          out_valid_q;
	ihq_pkg::out_item_t            out_q;

	// slot memory and key map ports
	logic                          sl_we;
	logic [ihq_pkg::SLOT_W-1:0]    sl_waddr, sl_raddr;
	ihq_pkg::slot_ent_t            sl_wdata, sl_rdata;
	logic                          ks_we;
	logic [ihq_pkg::KEY_W-1:0]     ks_waddr, ks_raddr;
	logic [ihq_pkg::FILL_W-1:0]    ks_wdata, ks_rdata;

	logic                          accept;
	logic                          phase_end;
	logic [ihq_pkg::FILL_W-1:0]    last;
	logic [ihq_pkg::SLOT_W-1:0]    parent;
	logic [ihq_pkg::FILL_W:0]      lidx, ridx;
	logic                          r_in;
	logic                          pick_r;
	ihq_pkg::slot_ent_t            child;
	logic [ihq_pkg::SLOT_W-1:0]    child_idx;
	logic                          mov_wins_up, child_wins;
	logic                          present;

	function automatic logic beats(input logic mm, input logic [ihq_pkg::PRIO_W-1:0] a,
		input logic [ihq_pkg::PRIO_W-1:0] b);
		return mm ? (a < b) : (a > b);
	endfunction

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == ihq_pkg::S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign last      = fill_q - ihq_pkg::FILL_W'(1);
	assign parent    = (hole_q - ihq_pkg::SLOT_W'(1)) >> 1;
	assign lidx      = {1'b0, hole_q, 1'b1};
	assign ridx      = lidx + (ihq_pkg::FILL_W + 1)'(1);
	assign r_in      = (ridx < {1'b0, fill_q});
	assign present   = !ks_rdata[ihq_pkg::FILL_W-1];

	// child choice: left when there is no right child or when left is strictly better than right
	assign pick_r      = has_r_q && !beats(min_mode_q, lft_q.prio, sl_rdata.prio);
	assign child       = pick_r ? sl_rdata : lft_q;
	assign child_idx   = pick_r ? (lidx[ihq_pkg::SLOT_W-1:0] + ihq_pkg::SLOT_W'(1))
	                            : lidx[ihq_pkg::SLOT_W-1:0];
	assign child_wins  = beats(min_mode_q, child.prio, mov_q.prio);
	assign mov_wins_up = beats(min_mode_q, mov_q.prio, sl_rdata.prio);

	ihq_ram #(.WIDTH(ihq_pkg::KEY_W + ihq_pkg::PRIO_W), .DEPTH(ihq_pkg::CAPACITY)) u_slots (
		.clk  (clk),
		.we   (sl_we),
		.waddr(sl_waddr),
		.wdata(sl_wdata),
		.raddr(sl_raddr),
		.rdata(sl_rdata)
	);

	ihq_ram #(.WIDTH(ihq_pkg::FILL_W), .DEPTH(ihq_pkg::KEY_COUNT)) u_keymap (
		.clk  (clk),
		.we   (ks_we),
		.waddr(ks_waddr),
		.wdata(ks_wdata),
		.raddr(ks_raddr),
		.rdata(ks_rdata)
	);

	// sequencer: next state and memory controls
	always_comb begin
		state_d   = state_q;
		phase_end = 1'b0;
		sl_we     = 1'b0;
		sl_waddr  = hole_q;
		sl_wdata  = mov_q;
		sl_raddr  = hole_q;
		ks_we     = 1'b0;
		ks_waddr  = key_q;
		ks_wdata  = ihq_pkg::NO_SLOT;
		ks_raddr  = key_q;
		case (state_q)
			ihq_pkg::S_CLEAR: begin
				ks_we    = 1'b1;
				ks_waddr = clr_q;
				if (clr_q == ihq_pkg::SLOT_W'(ihq_pkg::KEY_COUNT - 1)) begin
					state_d = ihq_pkg::S_IDLE;
				end
			end
			ihq_pkg::S_IDLE: begin
				ks_raddr = in_data.key;
				if (accept) begin
					state_d = ihq_pkg::S_DISP;
				end
			end
			ihq_pkg::S_DISP: begin
				case (op_q)
					ihq_pkg::OP_INSERT, ihq_pkg::OP_SET: begin
						if (present || fill_q < ihq_pkg::FILL_W'(ihq_pkg::CAPACITY)) begin
							state_d = ihq_pkg::S_UP_RD;
						end else begin
							state_d = ihq_pkg::S_FIN_RD;
						end
					end
					ihq_pkg::OP_REMOVE: begin
						if (present) begin
							ks_we    = 1'b1;
							sl_raddr = last[ihq_pkg::SLOT_W-1:0];
							state_d  = (ks_rdata < last) ? ihq_pkg::S_LOAD_LAST
							                             : ihq_pkg::S_FIN_RD;
						end else begin
							state_d = ihq_pkg::S_FIN_RD;
						end
					end
					ihq_pkg::OP_POP: begin
						sl_raddr = '0;
						state_d  = (fill_q == '0) ? ihq_pkg::S_FIN_RD : ihq_pkg::S_POP_RD;
					end
					ihq_pkg::OP_DEC: begin
						sl_raddr = ks_rdata[ihq_pkg::SLOT_W-1:0];
						state_d  = present ? ihq_pkg::S_DEC_RD : ihq_pkg::S_FIN_RD;
					end
					default: begin
						state_d = ihq_pkg::S_FIN_RD;
					end
				endcase
			end
			ihq_pkg::S_POP_RD: begin
				ks_we    = 1'b1;
				ks_waddr = sl_rdata.key;
				sl_raddr = last[ihq_pkg::SLOT_W-1:0];
				state_d  = (fill_q > ihq_pkg::FILL_W'(1)) ? ihq_pkg::S_LOAD_LAST
				                                          : ihq_pkg::S_FIN_RD;
			end
			ihq_pkg::S_LOAD_LAST: begin
				state_d = up_q ? ihq_pkg::S_UP_RD : ihq_pkg::S_DN_RDL;
			end
			ihq_pkg::S_DEC_RD: begin
				state_d = ihq_pkg::S_UP_RD;
			end
			ihq_pkg::S_UP_RD: begin
				sl_raddr = parent;
				if (hole_q == '0) begin
					phase_end = 1'b1;
				end else begin
					state_d = ihq_pkg::S_UP_CMP;
				end
			end
			ihq_pkg::S_UP_CMP: begin
				if (mov_wins_up) begin
					sl_we    = 1'b1;
					sl_wdata = sl_rdata;
					ks_we    = 1'b1;
					ks_waddr = sl_rdata.key;
					ks_wdata = {1'b0, hole_q};
					state_d  = ihq_pkg::S_UP_RD;
				end else begin
					phase_end = 1'b1;
				end
			end
			ihq_pkg::S_DN_RDL: begin
				sl_raddr = lidx[ihq_pkg::SLOT_W-1:0];
				if (lidx >= {1'b0, fill_q}) begin
					phase_end = 1'b1;
				end else begin
					state_d = ihq_pkg::S_DN_RDR;
				end
			end
			ihq_pkg::S_DN_RDR: begin
				sl_raddr = ridx[ihq_pkg::SLOT_W-1:0];
				state_d  = ihq_pkg::S_DN_CMP;
			end
			ihq_pkg::S_DN_CMP: begin
				if (child_wins) begin
					sl_we    = 1'b1;
					sl_wdata = child;
					ks_we    = 1'b1;
					ks_waddr = child.key;
					ks_wdata = {1'b0, hole_q};
					state_d  = ihq_pkg::S_DN_RDL;
				end else begin
					phase_end = 1'b1;
				end
			end
			ihq_pkg::S_WR_FIN: begin
				sl_we    = 1'b1;
				ks_we    = 1'b1;
				ks_waddr = mov_q.key;
				ks_wdata = {1'b0, hole_q};
				state_d  = ihq_pkg::S_FIN_RD;
			end
			ihq_pkg::S_FIN_RD: begin
				state_d = ihq_pkg::S_OUT;
			end
			ihq_pkg::S_OUT: begin
				if (!out_valid_q || out_ready) begin
					state_d = ihq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ihq_pkg::S_IDLE;
			end
		endcase
		// end of one sift direction: turn round or settle the moving entry
		if (phase_end) begin
			if (more_q) begin
				state_d = up_q ? ihq_pkg::S_DN_RDL : ihq_pkg::S_UP_RD;
			end else begin
				state_d = ihq_pkg::S_WR_FIN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ihq_pkg::S_CLEAR;
			clr_q       <= '0;
			fill_q      <= '0;
			min_mode_q  <= 1'b1;
			out_valid_q <= 1'b0;
			up_q        <= 1'b0;
			more_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				min_mode_q <= cfg_wdata;
			end
			if (state_q == ihq_pkg::S_CLEAR) begin
				clr_q <= clr_q + ihq_pkg::SLOT_W'(1);
			end
			// result register: load a new result or hand the held one over
			if (state_q == ihq_pkg::S_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (phase_end && more_q) begin
				more_q <= 1'b0;
				up_q   <= !up_q;
			end
			case (state_q)
				ihq_pkg::S_DISP: begin
					case (op_q)
						ihq_pkg::OP_INSERT, ihq_pkg::OP_SET: begin
							up_q <= 1'b1;
							if (present) begin
								more_q <= 1'b1;
							end else if (fill_q < ihq_pkg::FILL_W'(ihq_pkg::CAPACITY)) begin
								more_q <= 1'b0;
								fill_q <= fill_q + ihq_pkg::FILL_W'(1);
							end
						end
						ihq_pkg::OP_REMOVE: begin
							up_q   <= 1'b0;
							more_q <= 1'b1;
							if (present) begin
								fill_q <= last;
							end
						end
						ihq_pkg::OP_POP: begin
							up_q   <= 1'b0;
							more_q <= 1'b0;
						end
						ihq_pkg::OP_DEC: begin
							up_q   <= 1'b1;
							more_q <= 1'b1;
						end
						default: begin
							more_q <= 1'b0;
						end
					endcase
				end
				ihq_pkg::S_POP_RD: begin
					fill_q <= last;
				end
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ihq_pkg::S_IDLE: begin
				if (accept) begin
					op_q   <= in_data.opcode;
					key_q  <= in_data.key;
					prio_q <= in_data.priority_req ^ ihq_pkg::SIGN_FLIP;
					best_q <= '0;
					stat_q <= ihq_pkg::STAT_OK;
				end
			end
			ihq_pkg::S_DISP: begin
				mov_q.key  <= key_q;
				mov_q.prio <= prio_q;
				case (op_q)
					ihq_pkg::OP_INSERT, ihq_pkg::OP_SET: begin
						if (!present && fill_q < ihq_pkg::FILL_W'(ihq_pkg::CAPACITY)) begin
							hole_q <= fill_q[ihq_pkg::SLOT_W-1:0];
						end else begin
							hole_q <= ks_rdata[ihq_pkg::SLOT_W-1:0];
						end
						if (!present && fill_q >= ihq_pkg::FILL_W'(ihq_pkg::CAPACITY)) begin
							stat_q <= ihq_pkg::STAT_FULL;
						end
					end
					ihq_pkg::OP_POP: begin
						hole_q <= '0;
						if (fill_q == '0) begin
							stat_q <= ihq_pkg::STAT_EMPTY;
						end
					end
					default: begin
						hole_q <= ks_rdata[ihq_pkg::SLOT_W-1:0];
					end
				endcase
			end
			ihq_pkg::S_POP_RD: begin
				best_q <= sl_rdata.key;
			end
			ihq_pkg::S_LOAD_LAST: begin
				mov_q <= sl_rdata;
			end
			ihq_pkg::S_DEC_RD: begin
				// saturate at the most negative value
				mov_q.prio <= (sl_rdata.prio >= ihq_pkg::ONE_UNIT)
				            ? sl_rdata.prio - ihq_pkg::ONE_UNIT : '0;
			end
			ihq_pkg::S_UP_CMP: begin
				if (mov_wins_up) begin
					hole_q <= parent;
				end
			end
			ihq_pkg::S_DN_RDR: begin
				lft_q   <= sl_rdata;
				has_r_q <= r_in;
			end
			ihq_pkg::S_DN_CMP: begin
				if (child_wins) begin
					hole_q <= child_idx;
				end
			end
			ihq_pkg::S_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_q.best_key    <= best_q;
					out_q.is_member   <= present;
					out_q.slot_of_key <= ks_rdata;
					out_q.entry_count <= fill_q;
					out_q.status      <= stat_q;
				end
			end
			default: begin
			end
		endcase
	end

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= ihq_pkg::FILL_W'(ihq_pkg::CAPACITY))
		else $error("fill count beyond capacity");

	a_accept_disp: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ihq_pkg::S_DISP)
		else $error("accepted request not dispatched");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ihq_pkg::STAT_EMPTY |-> out_data.entry_count == '0)
		else $error("empty status with entries held");

endmodule

// ===== rtl/ihq_ram.sv =====
`timescale 1ns / 1ps

module ihq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

// scoreboard: holds results expected from the heap, in request order
class heap_result_board;
	ihq_pkg::out_item_t pending_q[$];
	int                 mismatch_count;

	function void note_request(ihq_pkg::out_item_t expected);
		pending_q.push_back(expected);
	endfunction

	task report_mismatch(string what);
		$display("mismatch: %s", what);
		mismatch_count++;
	endtask

	task check_result(ihq_pkg::out_item_t got);
		ihq_pkg::out_item_t want;
		if (pending_q.size() == 0) begin
			report_mismatch("result with nothing expected");
			return;
		end
		want = pending_q.pop_front();
		if (got.best_key !== want.best_key)
			report_mismatch($sformatf("best_key got %0h expected %0h",
				got.best_key, want.best_key));
		if (got.is_member !== want.is_member)
			report_mismatch($sformatf("is_member got %0h expected %0h",
				got.is_member, want.is_member));
		if (got.slot_of_key !== want.slot_of_key)
			report_mismatch($sformatf("slot_of_key got %0h expected %0h",
				got.slot_of_key, want.slot_of_key));
		if (got.entry_count !== want.entry_count)
			report_mismatch($sformatf("entry_count got %0h expected %0h",
				got.entry_count, want.entry_count));
		if (got.status !== want.status)
			report_mismatch($sformatf("status got %0h expected %0h",
				got.status, want.status));
	endtask
endclass

module testbench;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_ready;
	ihq_pkg::in_item_t  in_data = '0;
	logic               out_valid;
	logic               out_ready = 0;
	ihq_pkg::out_item_t out_data;
	logic               cfg_we = 0;
	logic               cfg_wdata = 0;

	heap_result_board board = new();

	// predictor state: heap slots, key map, fill and order mode
	logic [ihq_pkg::KEY_W-1:0]  heap_key [ihq_pkg::CAPACITY];
	logic [ihq_pkg::PRIO_W-1:0] heap_prio [ihq_pkg::CAPACITY];
	logic [ihq_pkg::FILL_W-1:0] key_slot [ihq_pkg::KEY_COUNT];
	int                         heap_fill;
	bit                         order_min;

	// random idling switches; quiet at the end of the run
	bit sender_idles = 1;
	bit receiver_idles = 1;
	// long hold-off: asked for by the main sequence, counted by the receiver
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_cycles;
	longint cycle_count = 0;

	indexed_binary_heap_queue_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 1500000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic bit prio_beats(logic [ihq_pkg::PRIO_W-1:0] a,
			logic [ihq_pkg::PRIO_W-1:0] b);
		return order_min ? (a < b) : (a > b);
	endfunction

	function automatic void slots_swap(int a, int b);
		logic [ihq_pkg::KEY_W-1:0]  k;
		logic [ihq_pkg::PRIO_W-1:0] p;
		k = heap_key[a]; p = heap_prio[a];
		heap_key[a] = heap_key[b]; heap_prio[a] = heap_prio[b];
		heap_key[b] = k; heap_prio[b] = p;
		key_slot[heap_key[a]] = ihq_pkg::FILL_W'(a);
		key_slot[heap_key[b]] = ihq_pkg::FILL_W'(b);
	endfunction

	function automatic int climb(int s);
		int up;
		while (s > 0) begin
			up = (s - 1) / 2;
			if (!prio_beats(heap_prio[s], heap_prio[up]))
				break;
			slots_swap(s, up);
			s = up;
		end
		return s;
	endfunction

	function automatic int sink(int s);
		int l, c;
		forever begin
			l = 2 * s + 1;
			if (l >= heap_fill)
				break;
			c = l;
			if (l + 1 < heap_fill)
				c = prio_beats(heap_prio[l], heap_prio[l + 1]) ? l : l + 1;
			if (!prio_beats(heap_prio[c], heap_prio[s]))
				break;
			slots_swap(s, c);
			s = c;
		end
		return s;
	endfunction

	// works out the result of one heap request and updates the copy
	function automatic ihq_pkg::out_item_t heap_outcome(ihq_pkg::in_item_t req);
		ihq_pkg::out_item_t         res;
		logic [ihq_pkg::PRIO_W-1:0] p;
		int                         cur, last;
		res = '0;
		p = req.priority_req ^ ihq_pkg::SIGN_FLIP;
		cur = (key_slot[req.key] == ihq_pkg::NO_SLOT) ? -1 : int'(key_slot[req.key]);
		case (req.opcode)
			ihq_pkg::OP_INSERT, ihq_pkg::OP_SET: begin
				if (cur >= 0) begin
					heap_prio[cur] = p;
					void'(sink(climb(cur)));
				end else if (heap_fill >= ihq_pkg::CAPACITY) begin
					res.status = ihq_pkg::STAT_FULL;
				end else begin
					heap_key[heap_fill] = req.key;
					heap_prio[heap_fill] = p;
					key_slot[req.key] = ihq_pkg::FILL_W'(heap_fill);
					heap_fill++;
					void'(climb(heap_fill - 1));
				end
			end
			ihq_pkg::OP_REMOVE: begin
				if (cur >= 0) begin
					last = heap_fill - 1;
					key_slot[req.key] = ihq_pkg::NO_SLOT;
					heap_fill = last;
					if (cur < last) begin
						heap_key[cur] = heap_key[last];
						heap_prio[cur] = heap_prio[last];
						key_slot[heap_key[cur]] = ihq_pkg::FILL_W'(cur);
						void'(climb(sink(cur)));
					end
				end
			end
			ihq_pkg::OP_POP: begin
				if (heap_fill == 0) begin
					res.status = ihq_pkg::STAT_EMPTY;
				end else begin
					last = heap_fill - 1;
					res.best_key = heap_key[0];
					key_slot[heap_key[0]] = ihq_pkg::NO_SLOT;
					heap_fill = last;
					if (last > 0) begin
						heap_key[0] = heap_key[last];
						heap_prio[0] = heap_prio[last];
						key_slot[heap_key[0]] = '0;
						void'(sink(0));
					end
				end
			end
			ihq_pkg::OP_DEC: begin
				if (cur >= 0) begin
					// saturate at the most negative value
					heap_prio[cur] = (heap_prio[cur] >= ihq_pkg::ONE_UNIT) ?
						heap_prio[cur] - ihq_pkg::ONE_UNIT : '0;
					void'(sink(climb(cur)));
				end
			end
			default: ;
		endcase
		res.slot_of_key = key_slot[req.key];
		res.is_member = (key_slot[req.key] != ihq_pkg::NO_SLOT);
		res.entry_count = ihq_pkg::FILL_W'(heap_fill);
		return res;
	endfunction

	// receiver: random stalls, plus a long hold-off when asked
	always begin
		@(negedge clk);
		if (hold_asks != hold_seen) begin
			hold_seen = hold_asks;
			out_ready <= 0;
			for (hold_cycles = 0; hold_cycles < 300; hold_cycles++)
				@(negedge clk);
		end else if (receiver_idles && $urandom_range(0, 5) == 0)
			out_ready <= 0;
		else
			out_ready <= 1;
	end

	always @(posedge clk)
		if (out_valid && out_ready)
			board.check_result(out_data);

	task automatic send_request(logic [2:0] op, logic [ihq_pkg::KEY_W-1:0] k,
			logic [ihq_pkg::PRIO_W-1:0] p);
		ihq_pkg::in_item_t req;
		int gap;
		@(negedge clk);
		if (sender_idles && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 8);
			repeat (gap) @(negedge clk);
		end
		req.opcode = op;
		req.key = k;
		req.priority_req = p;
		in_valid <= 1;
		in_data <= req;
		do @(posedge clk); while (!in_ready);
		board.note_request(heap_outcome(req));
		@(negedge clk);
		in_valid <= 0;
	endtask

	task automatic wait_drained();
		while (board.pending_q.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_mode(bit m);
		wait_drained();
		cfg_we <= 1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we <= 0;
		order_min = m;
	endtask

	function automatic logic [ihq_pkg::PRIO_W-1:0] random_prio();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_8000;
			3: return {16'($urandom_range(0, 15)), 16'h0};
			default: return $urandom;
		endcase
	endfunction

	// keys drawn evenly from 0 to key_span; a small span makes requests hit held entries
	task automatic random_burst(int n, int key_span, int insert_bias);
		int r;
		logic [2:0] op;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < insert_bias) op = ihq_pkg::OP_INSERT;
			else if (r < insert_bias + 12) op = ihq_pkg::OP_POP;
			else if (r < insert_bias + 24) op = ihq_pkg::OP_REMOVE;
			else if (r < insert_bias + 36) op = ihq_pkg::OP_SET;
			else if (r < insert_bias + 48) op = ihq_pkg::OP_DEC;
			else op = 3'($urandom_range(5, 7));
			send_request(op, ihq_pkg::KEY_W'($urandom_range(0, key_span)), random_prio());
		end
	endtask

	initial begin
		for (int i = 0; i < ihq_pkg::KEY_COUNT; i++) key_slot[i] = ihq_pkg::NO_SLOT;
		heap_fill = 0;
		order_min = 1;
		repeat (12) @(negedge clk);
		arst_n = 1;

		// directed: empty pop, extremes, duplicates, ties, saturation
		send_request(ihq_pkg::OP_POP, 0, 0);
		send_request(ihq_pkg::OP_QUERY, 10'h3FF, 0);
		send_request(ihq_pkg::OP_INSERT, 10'h3FF, 32'h7FFF_FFFF);
		send_request(ihq_pkg::OP_INSERT, 0, 32'h8000_0000);
		send_request(ihq_pkg::OP_INSERT, 5, 32'h8000_8000);
		send_request(ihq_pkg::OP_DEC, 5, 0);
		send_request(ihq_pkg::OP_DEC, 5, 0);
		send_request(ihq_pkg::OP_INSERT, 7, 32'h0001_0000);
		send_request(ihq_pkg::OP_INSERT, 8, 32'h0001_0000);
		send_request(ihq_pkg::OP_INSERT, 0, 32'hFFFF_FFFF);
		send_request(ihq_pkg::OP_SET, 9, 32'h0);
		send_request(ihq_pkg::OP_SET, 9, 32'h7000_0000);
		send_request(ihq_pkg::OP_REMOVE, 100, 0);
		send_request(ihq_pkg::OP_DEC, 100, 0);
		send_request(ihq_pkg::OP_REMOVE, 7, 0);
		send_request(3'd6, 8, 0);
		send_request(3'd7, 9, 0);
		send_request(ihq_pkg::OP_POP, 0, 0);
		send_request(ihq_pkg::OP_POP, 0, 0);
		write_mode(0);
		send_request(ihq_pkg::OP_POP, 0, 0);
		send_request(ihq_pkg::OP_INSERT, 3, 32'h1234_5678);
		write_mode(1);

		random_burst(200, 63, 40);
		// long receiver hold-off so the block backs up and stalls its input
		hold_asks++;
		random_burst(20, 63, 40);
		wait_drained();
		write_mode(0);
		// insert-heavy over the whole key range so the heap grows deep
		random_burst(250, 1023, 75);
		// order flips with entries held
		write_mode(1);
		random_burst(150, 1023, 30);
		sender_idles = 0;
		receiver_idles = 0;
		random_burst(150, 31, 35);

		wait_drained();
		if (board.mismatch_count == 0 && board.pending_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/ihq_pkg.sv
rtl/ihq_ram.sv
rtl/indexed_binary_heap_queue_unit.sv
tb/testbench.sv
